// ----- rtl/axf_pkg.sv -----
// Shared types and constants for the 32-bit integer ALU with arithmetic flags.
package axf_pkg;

  // Architectural sizes
  localparam int unsigned NUM_REGS    = 16;
  localparam int unsigned REG_IDX_W   = $clog2(NUM_REGS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Function codes as seen on the input port
  localparam logic [3:0] FUNC_ADD = 4'd0;
  localparam logic [3:0] FUNC_SUB = 4'd1;
  localparam logic [3:0] FUNC_AND = 4'd2;
  localparam logic [3:0] FUNC_OR  = 4'd3;
  localparam logic [3:0] FUNC_XOR = 4'd4;
  localparam logic [3:0] FUNC_MOV = 4'd5;
  localparam logic [3:0] FUNC_INC = 4'd6;
  localparam logic [3:0] FUNC_DEC = 4'd7;
  localparam logic [3:0] FUNC_NOT = 4'd8;
  localparam logic [3:0] FUNC_NEG = 4'd9;

  // Flag bit positions
  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 1;
  localparam int unsigned FL_AF = 2;
  localparam int unsigned FL_ZF = 3;
  localparam int unsigned FL_SF = 4;
  localparam int unsigned FL_OF = 5;

  // Decoded operation
  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_MOV,
    OP_INC,
    OP_DEC,
    OP_NOT,
    OP_NEG,
    OP_NOP
  } op_e;

  // One decoded instruction as it travels through the queue
  typedef struct packed {
    op_e         op;
    logic [3:0]  dst_reg;
    logic [3:0]  src_reg;
    logic        use_imm;
    logic [31:0] imm_value;
    logic [3:0]  insn_length;
    logic        event_pending;
  } insn_t;

endpackage

// ----- rtl/x86_alu32_with_flags_core.sv -----
// Top level of the 32-bit integer ALU with arithmetic flags.
// Executes one register instruction (add, sub, and, or, xor, mov, inc, dec, not,
// neg) per transfer in and returns one result per instruction, in order. The core
// sustains one instruction per cycle while the output side does not stall,
// dependent instructions included, since the register write of the retiring
// instruction is forwarded into the next one. An accepted instruction is written
// into the two-entry instruction queue, then moved into the execute stage as its
// operands are read from the register file, after which the adder and flag logic
// are captured in the result register. The sixteen registers, flags, instruction
// pointer and retired count are cleared by reset; inc and dec keep CF, logic
// operations clear OF, CF and AF, and mov and not leave all flags as they were.
module x86_alu32_with_flags_core import axf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [3:0]  dst_reg_i,
  input  logic [3:0]  src_reg_i,
  input  logic        use_imm_i,
  input  logic [31:0] imm_value_i,
  input  logic [3:0]  insn_length_i,
  input  logic        event_pending_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic [5:0]  flags_out_o,
  output logic [63:0] next_ip_o,
  output logic        stop_trace_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  insn_t push_insn, pop_insn;

  // Decode
  axf_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .dst_reg_i       (dst_reg_i),
    .src_reg_i       (src_reg_i),
    .use_imm_i       (use_imm_i),
    .imm_value_i     (imm_value_i),
    .insn_length_i   (insn_length_i),
    .event_pending_i (event_pending_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_insn_o     (push_insn)
  );

  // Decouple decode from execute
  axf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_insn_i  (push_insn),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_insn_o   (pop_insn)
  );

  // Execute and retire
  axf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_insn_i     (pop_insn),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .flags_out_o    (flags_out_o),
    .next_ip_o      (next_ip_o),
    .stop_trace_o   (stop_trace_o)
  );

endmodule

// ----- rtl/axf_front.sv -----
// Front end: accept instructions and decode the function code.
module axf_front import axf_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [3:0]  dst_reg_i,
  input  logic [3:0]  src_reg_i,
  input  logic        use_imm_i,
  input  logic [31:0] imm_value_i,
  input  logic [3:0]  insn_length_i,
  input  logic        event_pending_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output insn_t       push_insn_o
);

  op_e op;

  // Map function codes onto operations; unused codes retire as no-ops
  always_comb begin
    case (func_i)
      FUNC_ADD: op = OP_ADD;
      FUNC_SUB: op = OP_SUB;
      FUNC_AND: op = OP_AND;
      FUNC_OR:  op = OP_OR;
      FUNC_XOR: op = OP_XOR;
      FUNC_MOV: op = OP_MOV;
      FUNC_INC: op = OP_INC;
      FUNC_DEC: op = OP_DEC;
      FUNC_NOT: op = OP_NOT;
      FUNC_NEG: op = OP_NEG;
      default:  op = OP_NOP;
    endcase
  end

  // Build the queue entry
  always_comb begin
    push_insn_o.op            = op;
    push_insn_o.dst_reg       = dst_reg_i;
    push_insn_o.src_reg       = src_reg_i;
    push_insn_o.use_imm       = use_imm_i;
    push_insn_o.imm_value     = imm_value_i;
    push_insn_o.insn_length   = insn_length_i;
    push_insn_o.event_pending = event_pending_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

// ----- rtl/axf_queue.sv -----
// Short instruction queue between the front end and the execute back end.
module axf_queue import axf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  insn_t push_insn_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output insn_t pop_insn_o
);

  insn_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_insn_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries on transfer in
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_insn_i;
    end
  end

endmodule

// ----- rtl/axf_back.sv -----
// Back end: register read, execute with flags, write back and result register.
module axf_back import axf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  insn_t       pop_insn_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic [5:0]  flags_out_o,
  output logic [63:0] next_ip_o,
  output logic        stop_trace_o
);

  // Architectural state
  logic [31:0] rf_q [NUM_REGS];
  logic [5:0]  flags_q, flags_d;
  logic [63:0] ip_q, ip_d;
  logic [63:0] retired_q;

  // Execute stage
  logic        ex_valid_q;
  insn_t       ex_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic        ex_fire;

  // Last register write, for forwarding into the execute stage
  logic                 lw_valid_q;
  logic [REG_IDX_W-1:0] lw_idx_q;
  logic [31:0]          lw_data_q;

  // Result register
  logic        out_valid_q;
  logic [31:0] result_q;
  logic [5:0]  flags_out_q;
  logic [63:0] next_ip_q;
  logic        stop_q;

  logic        pop_a_ok, pop_b_ok, dst_ok;
  logic [31:0] a, b, op_a, op_b, b_x, r;
  logic [32:0] sum;
  logic        sub, arith, logic_op, keep_cf, wr_en;
  logic        cf, af, of_bit, pf, zf, sf;

  assign ex_fire     = ex_valid_q && (!out_valid_q || out_ready_i);
  assign pop_ready_o = !ex_valid_q || ex_fire;

  assign pop_a_ok = ({1'b0, pop_insn_i.dst_reg} < 5'(NUM_REGS));
  assign pop_b_ok = ({1'b0, pop_insn_i.src_reg} < 5'(NUM_REGS));
  assign dst_ok   = ({1'b0, ex_q.dst_reg} < 5'(NUM_REGS));

  // Load the execute stage and read the register file on transfer out of the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (pop_valid_i && pop_ready_o) begin
      ex_valid_q <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      ex_q   <= pop_insn_i;
      rd_a_q <= pop_a_ok ? rf_q[pop_insn_i.dst_reg[REG_IDX_W-1:0]] : '0;
      rd_b_q <= pop_b_ok ? rf_q[pop_insn_i.src_reg[REG_IDX_W-1:0]] : '0;
    end
  end

  // Forward the write that retired in the same cycle as the read
  always_comb begin
    a = rd_a_q;
    if (lw_valid_q && dst_ok && (lw_idx_q == ex_q.dst_reg[REG_IDX_W-1:0])) begin
      a = lw_data_q;
    end
    b = rd_b_q;
    if (lw_valid_q && ({1'b0, ex_q.src_reg} < 5'(NUM_REGS)) &&
        (lw_idx_q == ex_q.src_reg[REG_IDX_W-1:0])) begin
      b = lw_data_q;
    end
    if (ex_q.use_imm) begin
      b = ex_q.imm_value;
    end
  end

  // Select adder operands and the kind of flag update
  always_comb begin
    op_a     = a;
    op_b     = b;
    sub      = 1'b0;
    arith    = 1'b0;
    logic_op = 1'b0;
    keep_cf  = 1'b0;
    wr_en    = 1'b1;
    r        = a;
    case (ex_q.op)
      OP_ADD: arith = 1'b1;
      OP_SUB: begin
        arith = 1'b1;
        sub   = 1'b1;
      end
      OP_INC: begin
        arith   = 1'b1;
        op_b    = 32'd1;
        keep_cf = 1'b1;
      end
      OP_DEC: begin
        arith   = 1'b1;
        sub     = 1'b1;
        op_b    = 32'd1;
        keep_cf = 1'b1;
      end
      OP_NEG: begin
        arith = 1'b1;
        sub   = 1'b1;
        op_a  = 32'd0;
        op_b  = a;
      end
      OP_AND: begin
        logic_op = 1'b1;
        r        = a & b;
      end
      OP_OR: begin
        logic_op = 1'b1;
        r        = a | b;
      end
      OP_XOR: begin
        logic_op = 1'b1;
        r        = a ^ b;
      end
      OP_MOV:  r = b;
      OP_NOT:  r = ~a;
      default: wr_en = 1'b0;
    endcase
    b_x = op_b ^ {32{sub}};
    sum = {1'b0, op_a} + {1'b0, b_x} + {32'd0, sub};
    if (arith) begin
      r = sum[31:0];
    end
  end

  // Compute flags by x86 rules
  always_comb begin
    pf     = ~^r[7:0];
    zf     = (r == '0);
    sf     = r[31];
    cf     = sum[32] ^ sub;
    af     = op_a[4] ^ op_b[4] ^ r[4];
    of_bit = sub ? ((op_a[31] ^ op_b[31]) & (op_a[31] ^ r[31]))
                 : ((op_a[31] ^ r[31]) & (op_b[31] ^ r[31]));
    if (keep_cf) begin
      cf = flags_q[FL_CF];
    end
    flags_d = flags_q;
    if (arith) begin
      flags_d = {of_bit, sf, zf, af, pf, cf};
    end else if (logic_op) begin
      flags_d = {1'b0, sf, zf, 1'b0, pf, 1'b0};
    end
    ip_d = ip_q + {60'd0, ex_q.insn_length};
  end

  // Retire: update state and the forwarding record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      ip_q       <= '0;
      retired_q  <= '0;
      lw_valid_q <= 1'b0;
    end else if (ex_fire) begin
      flags_q   <= flags_d;
      ip_q      <= ip_d;
      retired_q <= retired_q + 64'd1;
      if (wr_en && dst_ok) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire && wr_en && dst_ok) begin
      lw_idx_q  <= ex_q.dst_reg[REG_IDX_W-1:0];
      lw_data_q <= r;
    end
  end

  // Register file, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i] <= '0;
      end
    end else if (ex_fire && wr_en && dst_ok) begin
      rf_q[ex_q.dst_reg[REG_IDX_W-1:0]] <= r;
    end
  end

  // Hold the result until the transfer out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      result_q    <= r;
      flags_out_q <= flags_d;
      next_ip_q   <= ip_d;
      stop_q      <= ex_q.event_pending;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign flags_out_o    = flags_out_q;
  assign next_ip_o      = next_ip_q;
  assign stop_trace_o   = stop_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 32-bit integer ALU with arithmetic flags.
`timescale 1ns / 100ps

module tb_top;
  import axf_pkg::*;

  // Function codes the core leaves unused
  localparam logic [3:0] FUNC_UNUSED_LO = 4'd10;
  localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;

  localparam int IDLE_PCT      = 26;
  localparam int RANDOM_INSNS  = 1850;
  localparam int HOLD_START    = 300;
  localparam int HOLD_CYCLES   = 160;
  localparam int QUIET_START   = 1200;
  localparam int QUIET_CYCLES  = 500;
  localparam int DRAIN_CYCLES  = 10;

  // One instruction as offered on the input side
  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic        use_imm;
    logic [31:0] imm;
    logic [3:0]  len;
    logic        ev;
    logic        drain_first;
  } tb_insn_t;

  // Outcome of one retired instruction
  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  flags;
    logic [63:0] ip;
    logic        stop;
  } retire_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  func_i = FUNC_ADD;
  logic [3:0]  dst_reg_i = '0;
  logic [3:0]  src_reg_i = '0;
  logic        use_imm_i = 1'b0;
  logic [31:0] imm_value_i = '0;
  logic [3:0]  insn_length_i = '0;
  logic        event_pending_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_value_o;
  logic [5:0]  flags_out_o;
  logic [63:0] next_ip_o;
  logic        stop_trace_o;

  x86_alu32_with_flags_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .dst_reg_i       (dst_reg_i),
    .src_reg_i       (src_reg_i),
    .use_imm_i       (use_imm_i),
    .imm_value_i     (imm_value_i),
    .insn_length_i   (insn_length_i),
    .event_pending_i (event_pending_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .flags_out_o     (flags_out_o),
    .next_ip_o       (next_ip_o),
    .stop_trace_o    (stop_trace_o)
  );

  // Architectural state mirrored by the predictor
  logic [31:0] gpr [NUM_REGS];
  logic [5:0]  flag_reg = '0;
  logic [63:0] ip_reg = '0;

  tb_insn_t insn_q[$];
  retire_t  retire_q[$];
  tb_insn_t cur;
  retire_t  want;

  int unsigned issued_cnt = 0;
  int unsigned retired_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned ev_cnt = 0;
  int unsigned unused_cnt = 0;
  logic        rx_hold = 1'b0;
  logic        quiet = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Parity, zero and sign from a 32-bit result
  function automatic logic [5:0] szp_flags(logic [31:0] r);
    logic [5:0] f;
    f        = '0;
    f[FL_PF] = ~^r[7:0];
    f[FL_ZF] = (r == '0);
    f[FL_SF] = r[31];
    return f;
  endfunction

  function automatic logic [5:0] add_flags(logic [31:0] a, logic [31:0] b, logic [31:0] r);
    logic [31:0] carries;
    logic [31:0] ovf;
    logic [5:0]  f;
    carries  = a ^ b ^ r;
    ovf      = (a ^ r) & (b ^ r);
    f        = szp_flags(r);
    f[FL_CF] = (r < a);
    f[FL_AF] = carries[4];
    f[FL_OF] = ovf[31];
    return f;
  endfunction

  function automatic logic [5:0] sub_flags(logic [31:0] a, logic [31:0] b, logic [31:0] r);
    logic [31:0] borrows;
    logic [31:0] ovf;
    logic [5:0]  f;
    borrows  = a ^ b ^ r;
    ovf      = (a ^ b) & (a ^ r);
    f        = szp_flags(r);
    f[FL_CF] = (a < b);
    f[FL_AF] = borrows[4];
    f[FL_OF] = ovf[31];
    return f;
  endfunction

  // Execute one instruction against the mirrored state and return its outcome
  function automatic retire_t execute_insn(tb_insn_t it);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [5:0]  f;
    logic        wr;
    retire_t     res;
    a  = gpr[it.dst];
    b  = it.use_imm ? it.imm : gpr[it.src];
    r  = a;
    f  = flag_reg;
    wr = 1'b1;
    case (it.func)
      FUNC_ADD: begin
        r = a + b;
        f = add_flags(a, b, r);
      end
      FUNC_SUB: begin
        r = a - b;
        f = sub_flags(a, b, r);
      end
      FUNC_AND: begin
        r = a & b;
        f = szp_flags(r);
      end
      FUNC_OR: begin
        r = a | b;
        f = szp_flags(r);
      end
      FUNC_XOR: begin
        r = a ^ b;
        f = szp_flags(r);
      end
      FUNC_MOV: r = b;
      FUNC_INC: begin
        r        = a + 32'd1;
        f        = add_flags(a, 32'd1, r);
        f[FL_CF] = flag_reg[FL_CF];
      end
      FUNC_DEC: begin
        r        = a - 32'd1;
        f        = sub_flags(a, 32'd1, r);
        f[FL_CF] = flag_reg[FL_CF];
      end
      FUNC_NOT: r = ~a;
      FUNC_NEG: begin
        r = 32'd0 - a;
        f = sub_flags(32'd0, a, r);
      end
      default: wr = 1'b0;
    endcase
    if (wr) gpr[it.dst] = r;
    flag_reg  = f;
    ip_reg    = ip_reg + 64'(it.len);
    res.value = r;
    res.flags = f;
    res.ip    = ip_reg;
    res.stop  = it.ev;
    return res;
  endfunction

  task automatic queue_insn(logic [3:0] func, logic [3:0] dst, logic [3:0] src,
                            logic use_imm, logic [31:0] imm, logic [3:0] len,
                            logic ev, logic drain_first);
    tb_insn_t it;
    it.func        = func;
    it.dst         = dst;
    it.src         = src;
    it.use_imm     = use_imm;
    it.imm         = imm;
    it.len         = len;
    it.ev          = ev;
    it.drain_first = drain_first;
    insn_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(0, 31));
      default: return 32'($urandom);
    endcase
  endfunction

  // Count cycles and open the long output hold-off and the no-idle window
  always @(posedge clk_i) begin
    if (rst_ni) cycle_cnt <= cycle_cnt + 1;
    rx_hold <= (cycle_cnt >= HOLD_START) && (cycle_cnt < HOLD_START + HOLD_CYCLES);
    quiet   <= (cycle_cnt >= QUIET_START) && (cycle_cnt < QUIET_START + QUIET_CYCLES);
  end

  // Drive instructions in; predict each one at its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        retire_q.push_back(execute_insn(cur));
        issued_cnt <= issued_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (insn_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT) &&
            !(insn_q[0].drain_first && (in_valid_i || issued_cnt != retired_cnt))) begin
          cur = insn_q.pop_front();
          if (cur.ev) ev_cnt++;
          if (cur.func >= FUNC_UNUSED_LO) unused_cnt++;
          func_i          <= cur.func;
          dst_reg_i       <= cur.dst;
          src_reg_i       <= cur.src;
          use_imm_i       <= cur.use_imm;
          imm_value_i     <= cur.imm;
          insn_length_i   <= cur.len;
          event_pending_i <= cur.ev;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (retired_cnt >= issued_cnt) begin
          $error("result with no instruction outstanding: result_value %h", result_value_o);
          fail_cnt++;
        end else begin
          want = retire_q.pop_front();
          if (result_value_o !== want.value) begin
            $error("result_value mismatch: expected %h, actual %h", want.value, result_value_o);
            fail_cnt++;
          end
          if (flags_out_o !== want.flags) begin
            $error("flags_out mismatch: expected %b, actual %b", want.flags, flags_out_o);
            fail_cnt++;
          end
          if (next_ip_o !== want.ip) begin
            $error("next_ip mismatch: expected %h, actual %h", want.ip, next_ip_o);
            fail_cnt++;
          end
          if (stop_trace_o !== want.stop) begin
            $error("stop_trace mismatch: expected %b, actual %b", want.stop, stop_trace_o);
            fail_cnt++;
          end
          retired_cnt <= retired_cnt + 1;
        end
      end
      out_ready_i <= !rx_hold && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Build the stimulus, release reset and wait for everything to retire
  initial begin
    int unsigned r;
    logic [3:0]  fn;
    for (int k = 0; k < NUM_REGS; k++) gpr[k] = '0;

    // Carry, zero, overflow and borrow at the extremes; zero and maximum length
    queue_insn(FUNC_MOV, 4'd0, 4'd0, 1'b1, 32'hFFFF_FFFF, 4'd1, 1'b0, 1'b0);
    queue_insn(FUNC_ADD, 4'd0, 4'd0, 1'b1, 32'h0000_0001, 4'd15, 1'b0, 1'b0);
    queue_insn(FUNC_MOV, 4'd1, 4'd0, 1'b1, 32'h7FFF_FFFF, 4'd0, 1'b0, 1'b0);
    queue_insn(FUNC_ADD, 4'd1, 4'd0, 1'b1, 32'h0000_0001, 4'd3, 1'b0, 1'b0);
    queue_insn(FUNC_SUB, 4'd2, 4'd0, 1'b1, 32'h0000_0001, 4'd2, 1'b0, 1'b0);
    // Inc and dec keep the carry; immediate ignored on unary ops
    queue_insn(FUNC_INC, 4'd3, 4'd9, 1'b1, 32'hDEAD_BEEF, 4'd1, 1'b0, 1'b0);
    queue_insn(FUNC_DEC, 4'd4, 4'd0, 1'b0, 32'h0, 4'd1, 1'b0, 1'b0);
    queue_insn(FUNC_SUB, 4'd1, 4'd1, 1'b0, 32'h0, 4'd2, 1'b0, 1'b0);
    // Negate zero and the most negative value
    queue_insn(FUNC_NEG, 4'd5, 4'd0, 1'b0, 32'h0, 4'd2, 1'b0, 1'b0);
    queue_insn(FUNC_MOV, 4'd5, 4'd0, 1'b1, 32'h8000_0000, 4'd5, 1'b0, 1'b0);
    queue_insn(FUNC_NEG, 4'd5, 4'd0, 1'b0, 32'h0, 4'd2, 1'b0, 1'b0);
    queue_insn(FUNC_NOT, 4'd5, 4'd0, 1'b0, 32'h0, 4'd2, 1'b1, 1'b0);
    // Logic ops clear carry, overflow and adjust
    queue_insn(FUNC_AND, 4'd2, 4'd5, 1'b0, 32'h0, 4'd3, 1'b0, 1'b0);
    queue_insn(FUNC_OR,  4'd15, 4'd2, 1'b0, 32'h0, 4'd3, 1'b0, 1'b0);
    queue_insn(FUNC_XOR, 4'd15, 4'd15, 1'b0, 32'h0, 4'd3, 1'b0, 1'b0);
    queue_insn(FUNC_XOR, 4'd14, 4'd0, 1'b1, 32'hAAAA_AAAA, 4'd6, 1'b0, 1'b0);
    queue_insn(FUNC_AND, 4'd14, 4'd0, 1'b1, 32'h5555_5555, 4'd6, 1'b0, 1'b0);
    // Unused codes retire without writing a register or the flags
    queue_insn(FUNC_UNUSED_LO, 4'd2, 4'd3, 1'b0, 32'h0, 4'd4, 1'b1, 1'b0);
    queue_insn(FUNC_UNUSED_HI, 4'd0, 4'd15, 1'b1, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b0);
    queue_insn(FUNC_INC, 4'd2, 4'd0, 1'b0, 32'h0, 4'd1, 1'b0, 1'b0);
    queue_insn(FUNC_DEC, 4'd14, 4'd0, 1'b0, 32'h0, 4'd1, 1'b0, 1'b0);
    // Adjust carry out of the low nibble from a register operand
    queue_insn(FUNC_MOV, 4'd13, 4'd0, 1'b1, 32'h0000_000F, 4'd2, 1'b0, 1'b0);
    queue_insn(FUNC_ADD, 4'd13, 4'd3, 1'b0, 32'h0, 4'd2, 1'b0, 1'b0);
    queue_insn(FUNC_SUB, 4'd6, 4'd15, 1'b0, 32'h0, 4'd7, 1'b0, 1'b0);

    // Random instructions; pause for a full drain twice
    for (int n = 0; n < RANDOM_INSNS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) fn = 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      else if (r < 20) fn = FUNC_MOV;
      else fn = 4'($urandom_range(FUNC_ADD, FUNC_NEG));
      queue_insn(fn, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), pick_imm(), 4'($urandom_range(1, 15)),
                 ($urandom_range(0, 7) == 0), (n == 0) || (n == RANDOM_INSNS / 2));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (insn_q.size() != 0 || in_valid_i);
    do @(posedge clk_i); while (retired_cnt != issued_cnt);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (retire_q.size() != 0) begin
      $error("%0d predicted results never arrived", retire_q.size());
      fail_cnt++;
    end
    $display("Retired %0d instructions (%0d with a pending event, %0d unused codes),",
             issued_cnt, ev_cnt, unused_cnt);
    $display("through a %0d-cycle output hold-off and two full drains.", HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("x86_alu32_with_flags_core test passed");
    end else begin
      $display("x86_alu32_with_flags_core test failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("x86_alu32_with_flags_core test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/axf_pkg.sv
rtl/axf_front.sv
rtl/axf_queue.sv
rtl/axf_back.sv
rtl/x86_alu32_with_flags_core.sv
tb/tb_top.sv
